// ===== hdl/mstr_pkg.sv =====
// Shared types and codes for the sample-to-chunk resolver.
`default_nettype none
package mstr_pkg;

   localparam int unsigned CHUNK_W  = 32;
   localparam int unsigned SPC_W    = 32;
   localparam int unsigned OFFSET_W = 64;
   localparam int unsigned SIZE_W   = 32;
   localparam int unsigned REQ_DATA_W = 160;
   localparam int unsigned RSP_DATA_W = 128;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_LOAD   = 2'd1,
      FUNC_CHUNK  = 2'd2,
      FUNC_SAMPLE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // Search wave that moves one cell per cycle along the entry chain.
   typedef struct packed {
      logic              run;   // leading run of matching entries not yet broken
      logic              found; // an entry has been picked
      logic [SPC_W-1:0]  pick;  // samples per chunk of the picked entry
   } wave_type;

   typedef struct packed {
      logic               wr_en;
      logic               in_range;
      logic [CHUNK_W-1:0] first;
      logic [SPC_W-1:0]   spc;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== hdl/mstr_cell.sv =====
// One cell of the entry chain: holds one table entry and forwards the search wave.
`default_nettype none
module mstr_cell
   import mstr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cell_ctrl_type      ctrl,
   input  wire logic [CHUNK_W-1:0] chunk,
   input  wire wave_type           wave_in,
   output wave_type                wave_out
);

   logic [CHUNK_W-1:0] first_ff;
   logic [SPC_W-1:0]   spc_ff;
   wave_type           wave_ff;
   wave_type           wave_in_c;
   logic               covers;

   assign covers = (first_ff <= chunk);

   // The first stored entry is always taken; later ones only while the run holds.
   always_comb begin
      wave_in_c = wave_in;
      if (ctrl.in_range && wave_in.run) begin
         if (covers || !wave_in.found) begin
            wave_in_c.pick  = spc_ff;
            wave_in_c.found = 1'b1;
         end
         wave_in_c.run = covers;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         first_ff <= ctrl.first;
         spc_ff   <= ctrl.spc;
      end
      if (reset) begin
         wave_ff <= '0;
      end else begin
         wave_ff <= wave_in_c;
      end
   end

   assign wave_out = wave_ff;

endmodule
`default_nettype wire

// ===== hdl/mp4_sample_table_resolver_unit.sv =====
// Top level of the sample-to-chunk resolver: control, chunk state and entry chain.
`default_nettype none
// Usage: items arrive on the req_ stream. req_tuser carries the function code
// (clear, load entry, chunk start, sample size) and req_tdata the operands.
// Results leave on the rsp_ stream: req_tuser-style status in rsp_tuser, and
// the sample offset, echoed size and chunk number in rsp_tdata.
// Clear, load and sample items are handled as they are accepted; a result of a load into a
// full table or of a sample is registered and shows up on rsp_ in the cycle after the item.
// A chunk start holds the block in the search state: the stored entries sit in a row
// of TABLE_DEPTH cells, and the search wave that picks the covering entry
// moves through one cell per cycle before the sample budget is loaded.
// Sample and load items therefore sustain one item per cycle outside a chunk search
// while the result register drains; chunk starts are bounded by the cell row length.
// The block holds a single output register. While a result waits and the
// receiver keeps rsp_tready low, req_tready stays low, so nothing is lost.
// Reset clears the entry count, chunk counter, running offset, sample budget
// and the output valid; table contents are only read below the entry count,
// so they need no clearing and the block is ready in the cycle after reset.
module mp4_sample_table_resolver_unit
   import mstr_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 64
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // entry_first_chunk[31:0], entry_samples_per_chunk[63:32],
   // chunk_offset[127:64], byte_size[159:128]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // sample_offset[63:0], sample_bytes[95:64], chunk_number[127:96]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // status[1:0]
   output logic [1:0]                 rsp_tuser
);

   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       entry_count_ff, entry_count_in;
   logic [CNT_W-1:0]       search_cnt_ff, search_cnt_in;
   logic [CHUNK_W-1:0]     chunk_counter_ff, chunk_counter_in;
   logic [OFFSET_W-1:0]    running_offset_ff, running_offset_in;
   logic [SPC_W-1:0]       samples_left_ff, samples_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   status_type             rsp_status_ff, rsp_status_in;

   func_type               func;
   logic [CHUNK_W-1:0]     in_first;
   logic [SPC_W-1:0]       in_spc;
   logic [OFFSET_W-1:0]    in_coff;
   logic [SIZE_W-1:0]      in_size;
   logic                   accept;
   logic                   table_full;
   logic                   load_wr;

   wave_type               wave [0:TABLE_DEPTH];

   assign func     = func_type'(req_tuser);
   assign in_first = req_tdata[31:0];
   assign in_spc   = req_tdata[63:32];
   assign in_coff  = req_tdata[127:64];
   assign in_size  = req_tdata[159:128];

   // Only one result register: a new item enters in the idle state when it is free or draining.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign table_full = (entry_count_ff >= CNT_W'(TABLE_DEPTH));
   assign load_wr    = accept && (func == FUNC_LOAD) && !table_full;

   // The wave enters the row with the run open and nothing picked yet.
   assign wave[0] = '{run: 1'b1, found: 1'b0, pick: '0};

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      cell_ctrl_type ctrl;

      assign ctrl.wr_en    = load_wr && (entry_count_ff[IDX_W-1:0] == IDX_W'(k));
      assign ctrl.in_range = (CNT_W'(k) < entry_count_ff);
      assign ctrl.first    = in_first;
      assign ctrl.spc      = in_spc;

      mstr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .chunk    (chunk_counter_ff),
         .wave_in  (wave[k]),
         .wave_out (wave[k+1])
      );
   end

   always_comb begin
      state_in          = state_ff;
      entry_count_in    = entry_count_ff;
      search_cnt_in     = search_cnt_ff;
      chunk_counter_in  = chunk_counter_ff;
      running_offset_in = running_offset_ff;
      samples_left_in   = samples_left_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_data_in       = rsp_data_ff;
      rsp_status_in     = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (func)
                  FUNC_CLEAR: begin
                     entry_count_in    = '0;
                     chunk_counter_in  = '0;
                     running_offset_in = '0;
                     samples_left_in   = '0;
                  end
                  FUNC_LOAD: begin
                     if (table_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '0;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        entry_count_in = entry_count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_CHUNK: begin
                     // The counter wraps; the search count restarts and the wave is checked against the new value.
                     chunk_counter_in  = chunk_counter_ff + CHUNK_W'(1);
                     running_offset_in = in_coff;
                     search_cnt_in     = '0;
                     state_in          = ST_SEARCH;
                  end
                  FUNC_SAMPLE: begin
                     rsp_valid_in = 1'b1;
                     if (samples_left_ff == '0) begin
                        rsp_data_in   = {chunk_counter_ff, in_size, OFFSET_W'(0)};
                        rsp_status_in = STATUS_DROPPED;
                     end else begin
                        rsp_data_in       = {chunk_counter_ff, in_size, running_offset_ff};
                        rsp_status_in     = STATUS_OK;
                        running_offset_in = running_offset_ff + OFFSET_W'(in_size);
                        samples_left_in   = samples_left_ff - SPC_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // Once the search count reaches TABLE_DEPTH, the wave at the row end reflects the new counter.
            if (search_cnt_ff == CNT_W'(TABLE_DEPTH)) begin
               samples_left_in = wave[TABLE_DEPTH].found ? wave[TABLE_DEPTH].pick : '0;
               state_in        = ST_IDLE;
            end else begin
               search_cnt_in = search_cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff          <= ST_IDLE;
         entry_count_ff    <= '0;
         search_cnt_ff     <= '0;
         chunk_counter_ff  <= '0;
         running_offset_ff <= '0;
         samples_left_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         entry_count_ff    <= entry_count_in;
         search_cnt_ff     <= search_cnt_in;
         chunk_counter_ff  <= chunk_counter_in;
         running_offset_ff <= running_offset_in;
         samples_left_ff   <= samples_left_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

// ===== hdl/mstr_checker.sv =====
// Port-level checks for the sample-to-chunk resolver, bound to the top level.
`default_nettype none
module mstr_checker
   import mstr_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser
);

   // A waiting result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn while stalled");

   // A new result only follows an accepted item.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result item without an accepted input item");

   // The single output register blocks input while a result is stalled.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while result stalled");

   // Dropped samples and full-table results carry no offset.
   a_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_DROPPED || rsp_tuser == STATUS_FULL)
      |-> rsp_tdata[63:0] == 64'd0)
      else $error("nonzero offset on a dropped or rejected item");

endmodule

bind mp4_sample_table_resolver_unit mstr_checker u_mstr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
